@@ design/mjpeg_multipart_deframer_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef MJPEG_MULTIPART_DEFRAMER_MACROS_SVH
`define MJPEG_MULTIPART_DEFRAMER_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define MJPEG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// When pre holds, post must hold on the next edge.
`define MJPEG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/mjpeg_pkg.sv @@
// Constants and helpers for the multipart MJPEG deframer.
package mjpeg_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int TAG_LEN     = 56;
  localparam int TAG_W       = 6;
  localparam logic [1:0] SKIP_AFTER_SPACE = 2'd3;

  // Boundary tag, first character in the top byte.
  localparam logic [8*TAG_LEN-1:0] TAG_TEXT =
    "--myboundary\r\nContent-Type: image/jpeg\r\nContent-Length: ";

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  // Character of the tag at position idx (idx below TAG_LEN).
  function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    for (int i = 0; i < TAG_LEN; i++) begin
      if (idx == TAG_W'(i)) ch = TAG_TEXT[8*(TAG_LEN-1-i) +: 8];
    end
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

@@ design/mjpeg_multipart_deframer.sv @@
// Multipart MJPEG deframer: tag hunt, length parse, payload pass-through.
// Output: each result is held in an output register, loaded when its input beat is accepted.
// Throughput: one input beat per cycle; only a held result with out_stall_i stalls input.
// Tag search is a prefix automaton whose fallback covers only the leading dashes.
// Reset (rst_ni low, asynchronous) returns to tag hunting with no result pending.
module mjpeg_multipart_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] payload_byte_o,
  output logic       last_of_frame_o
);
  import mjpeg_pkg::*;
  `include "mjpeg_multipart_deframer_macros.svh"

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;
  localparam int         ACC_W   = LENGTH_BITS + 4;

  logic [1:0]             phase_q, phase_d;
  logic [TAG_W-1:0]       tag_matched_q, tag_matched_d;
  logic [LENGTH_BITS-1:0] length_accum_q, length_accum_d;
  logic                   digit_seen_q, digit_seen_d;
  logic [1:0]             skip_left_q, skip_left_d;
  logic [LENGTH_BITS-1:0] payload_left_q, payload_left_d;

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] payload_q;
  logic       last_q;

  logic       res_valid;
  logic       res_kind;
  logic [7:0] res_byte;
  logic       res_last;

  logic       in_fire;
  logic       out_free;

  logic [TAG_W-1:0]       tag_next;
  logic [7:0]             cur_ch;
  logic [7:0]             prev_ch;
  logic [ACC_W-1:0]       acc_next;
  logic [1:0]             skip_dec;
  logic [LENGTH_BITS-1:0] pay_dec;
  logic                   is_digit;

  // Handshake: output register is free when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_fire    = in_valid_i && out_free;

  // Tag automaton step; any fallback prefix is made of leading dashes.
  always_comb begin
    cur_ch  = tag_char(tag_matched_q);
    prev_ch = (tag_matched_q == '0) ? 8'h00 : tag_char(tag_matched_q - TAG_W'(1));
    if (stream_byte_i == cur_ch) begin
      tag_next = tag_matched_q + TAG_W'(1);
    end else if (stream_byte_i == CH_DASH) begin
      tag_next = (prev_ch == CH_DASH) ? TAG_W'(2) : TAG_W'(1);
    end else begin
      tag_next = '0;
    end
  end

  // Decimal accumulate: accum * 10 + digit, with headroom for overflow check.
  assign is_digit = (stream_byte_i >= CH_ZERO) && (stream_byte_i <= CH_NINE);
  assign acc_next = {1'b0, length_accum_q, 3'b000} + {3'b000, length_accum_q, 1'b0}
                  + ACC_W'(stream_byte_i[3:0]);
  assign skip_dec = (skip_left_q != 2'd0) ? skip_left_q - 2'd1 : 2'd0;
  assign pay_dec  = (payload_left_q != '0) ? payload_left_q - LENGTH_BITS'(1) : '0;

  // Next state and result for the current beat.
  always_comb begin
    phase_d        = phase_q;
    tag_matched_d  = tag_matched_q;
    length_accum_d = length_accum_q;
    digit_seen_d   = digit_seen_q;
    skip_left_d    = skip_left_q;
    payload_left_d = payload_left_q;
    res_valid      = 1'b0;
    res_kind       = KIND_PAYLOAD;
    res_byte       = 8'h00;
    res_last       = 1'b0;
    if (mode_i) begin
      // Disconnect: drop everything, hunt again.
      phase_d        = PH_HUNT;
      tag_matched_d  = '0;
      length_accum_d = '0;
      digit_seen_d   = 1'b0;
      skip_left_d    = 2'd0;
      payload_left_d = '0;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (tag_next >= TAG_W'(TAG_LEN)) begin
            tag_matched_d  = '0;
            length_accum_d = '0;
            digit_seen_d   = 1'b0;
            phase_d        = PH_LEN;
          end else begin
            tag_matched_d = tag_next;
          end
        end
        PH_LEN: begin
          if (is_digit && (acc_next[ACC_W-1:LENGTH_BITS] == '0)) begin
            length_accum_d = acc_next[LENGTH_BITS-1:0];
            digit_seen_d   = 1'b1;
          end else if (!is_digit && is_ws(stream_byte_i) && digit_seen_q) begin
            skip_left_d = SKIP_AFTER_SPACE;
            phase_d     = PH_SKIP;
          end else begin
            // Malformed header: one error result.
            res_valid      = 1'b1;
            res_kind       = KIND_ERROR;
            phase_d        = PH_HUNT;
            tag_matched_d  = '0;
            length_accum_d = '0;
            digit_seen_d   = 1'b0;
            skip_left_d    = 2'd0;
            payload_left_d = '0;
          end
        end
        PH_SKIP: begin
          skip_left_d = skip_dec;
          if (skip_dec == 2'd0) begin
            if (length_accum_q == '0) begin
              phase_d        = PH_HUNT;
              tag_matched_d  = '0;
              digit_seen_d   = 1'b0;
              payload_left_d = '0;
            end else begin
              payload_left_d = length_accum_q;
              phase_d        = PH_DATA;
            end
          end
        end
        default: begin
          // Payload beat.
          res_valid      = 1'b1;
          res_byte       = stream_byte_i;
          payload_left_d = pay_dec;
          if (pay_dec == '0) begin
            res_last       = 1'b1;
            phase_d        = PH_HUNT;
            tag_matched_d  = '0;
            length_accum_d = '0;
            digit_seen_d   = 1'b0;
            skip_left_d    = 2'd0;
          end
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      tag_matched_q  <= '0;
      length_accum_q <= '0;
      digit_seen_q   <= 1'b0;
      skip_left_q    <= 2'd0;
      payload_left_q <= '0;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      tag_matched_q  <= tag_matched_d;
      length_accum_q <= length_accum_d;
      digit_seen_q   <= digit_seen_d;
      skip_left_q    <= skip_left_d;
      payload_left_q <= payload_left_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q    <= res_kind;
      payload_q <= res_byte;
      last_q    <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = payload_q;
  assign last_of_frame_o = last_q;

  // Checks on internal consistency.
  `MJPEG_ASSERT_ALWAYS(a_tag_range, tag_matched_q < TAG_W'(TAG_LEN), "tag count out of range")
  `MJPEG_ASSERT_ALWAYS(a_data_nonzero, (phase_q != PH_DATA) || (payload_left_q != '0), "data phase with nothing left")
  `MJPEG_ASSERT_ALWAYS(a_err_clean, !out_valid_q || (kind_q == KIND_PAYLOAD) || ((payload_q == 8'h00) && !last_q), "error result with payload bits")
  `MJPEG_ASSERT_NEXT(a_drop_hunts, in_fire && mode_i, (phase_q == PH_HUNT) && (tag_matched_q == '0) && !out_valid_q, "disconnect did not reset parser")
  `MJPEG_ASSERT_NEXT(a_skip_quiet, in_fire && (phase_q == PH_SKIP), !out_valid_q, "skipped byte produced a result")

endmodule

@@ dv/mjpeg_multipart_deframer_tb.sv @@
// Self-checking testbench for the multipart MJPEG deframer.
module mjpeg_multipart_deframer_tb;
  import mjpeg_pkg::*;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;
  localparam logic [7:0] WS_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_SKIP, PH_DATA} phase_e;

  // One stream beat, or a marker that makes the sender wait for the output to drain.
  typedef struct {
    bit         drain;
    logic       mode;
    logic [7:0] data;
  } stream_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       mode_i;
  logic [7:0] stream_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic [7:0] payload_byte_o;
  logic       last_of_frame_o;

  mjpeg_multipart_deframer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .last_of_frame_o(last_of_frame_o)
  );

  // Stimulus and scoreboard storage
  stream_beat_t stream_q[$];
  frame_out_t   frame_out_q[$];
  logic [7:0]   tag_bytes [TAG_LEN];
  int unsigned  n_items;
  int unsigned  n_fail;
  int unsigned  results_seen;
  int unsigned  cycle_cnt;
  bit           started;
  logic         in_acc;
  logic         out_acc;

  // Predicted deframer state
  phase_e                 phase_q;
  int unsigned            tag_pos;
  logic [LENGTH_BITS-1:0] len_acc;
  logic                   seen_digit;
  logic [1:0]             skip_cnt;
  logic [LENGTH_BITS-1:0] pay_left;

  // Sender and receiver pacing
  int unsigned tx_gap;
  bit          tx_burst;
  int unsigned rx_wait;
  int unsigned hold_left;
  bit          rx_burst;

  always #5 clk_i = ~clk_i;

  function automatic bit is_space(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic void hunt_reset();
    phase_q    = PH_HUNT;
    tag_pos    = 0;
    len_acc    = '0;
    seen_digit = 1'b0;
    skip_cnt   = '0;
    pay_left   = '0;
  endfunction

  // Longest tag prefix that is a suffix of the matched bytes followed by b.
  function automatic int unsigned next_match(int unsigned m, logic [7:0] b);
    int unsigned n;
    bit ok;
    if (m >= TAG_LEN) m = 0;
    for (n = m + 1; n > 0; n--) begin
      if (tag_bytes[n-1] != b) continue;
      ok = 1'b1;
      for (int k = 0; k < int'(n) - 1; k++) begin
        if (tag_bytes[k] != tag_bytes[m+1-n+k]) ok = 1'b0;
      end
      if (ok) return n;
    end
    return 0;
  endfunction

  // Advance the predicted state by one beat; returns 1 when a result is due.
  function automatic bit deframe_step(input logic md, input logic [7:0] b,
                                      output frame_out_t r);
    int unsigned     m;
    longint unsigned v;
    bit              has;
    r   = '0;
    has = 1'b0;
    if (md) begin
      hunt_reset();
    end else begin
      case (phase_q)
        PH_HUNT: begin
          m = next_match(tag_pos, b);
          if (m >= TAG_LEN) begin
            tag_pos    = 0;
            len_acc    = '0;
            seen_digit = 1'b0;
            phase_q    = PH_LEN;
          end else begin
            tag_pos = m;
          end
        end
        PH_LEN: begin
          has = 1'b1;
          if (b >= CH_ZERO && b <= CH_NINE) begin
            v = longint'(len_acc) * 10 + longint'(b - CH_ZERO);
            if (v <= LEN_MAX) begin
              len_acc    = v[LENGTH_BITS-1:0];
              seen_digit = 1'b1;
              has        = 1'b0;
            end
          end else if (is_space(b) && seen_digit) begin
            skip_cnt = SKIP_AFTER_SPACE;
            phase_q  = PH_SKIP;
            has      = 1'b0;
          end
          // malformed header
          if (has) begin
            r.kind = KIND_ERROR;
            hunt_reset();
          end
        end
        PH_SKIP: begin
          if (skip_cnt > 0) skip_cnt--;
          if (skip_cnt == 0) begin
            if (len_acc == 0) begin
              hunt_reset();
            end else begin
              pay_left = len_acc;
              phase_q  = PH_DATA;
            end
          end
        end
        default: begin
          has    = 1'b1;
          r.kind = KIND_PAYLOAD;
          r.data = b;
          if (pay_left > 0) pay_left--;
          if (pay_left == 0) begin
            r.last = 1'b1;
            hunt_reset();
          end
        end
      endcase
    end
    return has;
  endfunction

  // Stimulus helpers
  function automatic void push_byte(logic md, logic [7:0] b);
    stream_beat_t sb;
    sb.drain = 1'b0;
    sb.mode  = md;
    sb.data  = b;
    stream_q.push_back(sb);
    n_items++;
  endfunction

  function automatic void push_drain();
    stream_beat_t sb;
    sb.drain = 1'b1;
    sb.mode  = 1'b0;
    sb.data  = '0;
    stream_q.push_back(sb);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(1'b0, s[i]);
  endfunction

  function automatic void push_tag_prefix(int unsigned k);
    for (int unsigned i = 0; i < k; i++) push_byte(1'b0, tag_bytes[i]);
  endfunction

  function automatic void push_rand(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(1'b0, 8'($urandom_range(0, 255)));
  endfunction

  // Tag, length digits, terminating whitespace and three separator bytes.
  function automatic void push_header(string digits, logic [7:0] ws);
    push_tag_prefix(TAG_LEN);
    push_text(digits);
    push_byte(1'b0, ws);
    push_rand(3);
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || is_space(c));
    return c;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Sender: offers queued beats, drawing an idle gap for each one.
  always @(negedge clk_i) begin
    logic         nv;
    stream_beat_t sb;
    nv = in_valid_i;
    if (in_acc) nv = 1'b0;
    if (started && !nv) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (stream_q.size() > 0) begin
        if (stream_q[0].drain) begin
          if (frame_out_q.size() == 0) void'(stream_q.pop_front());
        end else begin
          sb = stream_q.pop_front();
          mode_i        <= sb.mode;
          stream_byte_i <= sb.data;
          nv = 1'b1;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 13);
          if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
        end
      end
    end
    in_valid_i <= nv;
  end

  // Receiver: random stall per result, plus two long hold-offs.
  always @(negedge clk_i) begin
    if (out_acc) begin
      if (results_seen == 20 || results_seen == 200) hold_left = 250;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 29) == 0) rx_burst = ~rx_burst;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: check output beats, then predict from accepted input beats.
  always @(posedge clk_i) begin
    frame_out_t got;
    frame_out_t want;
    frame_out_t res;
    if (!rst_ni) begin
      in_acc  <= 1'b0;
      out_acc <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        got.kind = kind_o;
        got.data = payload_byte_o;
        got.last = last_of_frame_o;
        if (frame_out_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected beat, expected none, actual kind %0d byte %0d last %0d",
                   $time, got.kind, got.data, got.last);
        end else begin
          want = frame_out_q.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("payload_byte", want.data, got.data);
          check_field("last_of_frame", want.last, got.last);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (deframe_step(mode_i, stream_byte_i, res)) frame_out_q.push_back(res);
      end
      in_acc  <= in_valid_i && !in_stall_o;
      out_acc <= out_valid_o && !out_stall_i;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("mjpeg_multipart_deframer regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned rand_start;
    int unsigned next_drain;
    int unsigned sel;
    int unsigned len;
    int unsigned k;
    string       ds;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = 1'b0;
    stream_byte_i = 8'h00;
    out_stall_i   = 1'b0;
    in_acc        = 1'b0;
    out_acc       = 1'b0;
    started       = 1'b0;
    n_items       = 0;
    n_fail        = 0;
    results_seen  = 0;
    cycle_cnt     = 0;
    tx_gap        = 0;
    tx_burst      = 1'b0;
    rx_wait       = 0;
    hold_left     = 0;
    rx_burst      = 1'b0;
    for (int i = 0; i < TAG_LEN; i++) tag_bytes[i] = TAG_TEXT[8*(TAG_LEN-1-i) +: 8];
    hunt_reset();

    // Directed: minimal frames, payload byte extremes, each whitespace terminator
    push_header("1", 8'h20);
    push_byte(1'b0, 8'h00);
    push_header("3", 8'h09);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'hA5);
    // empty frame, then a header with no digit
    push_header("0", 8'h0A);
    push_tag_prefix(TAG_LEN);
    push_byte(1'b0, 8'h0D);
    // stray characters at the digit and whitespace boundaries
    push_tag_prefix(TAG_LEN);
    push_byte(1'b0, 8'h2F);
    push_tag_prefix(TAG_LEN);
    push_text("12");
    push_byte(1'b0, 8'h3A);
    push_tag_prefix(TAG_LEN);
    push_byte(1'b0, 8'h08);
    push_tag_prefix(TAG_LEN);
    push_text("7");
    push_byte(1'b0, 8'h0E);
    // length overflow by one
    push_tag_prefix(TAG_LEN);
    push_text("16777216");
    // largest length, cut short by a disconnect
    push_header("16777215", 8'h0B);
    push_rand(5);
    push_byte(1'b1, 8'hFF);
    // leading zeros
    push_header("0002", 8'h0C);
    push_rand(2);
    // extra leading dash, and a fresh tag starting inside the old one
    push_byte(1'b0, CH_DASH);
    push_header("2", 8'h0D);
    push_rand(2);
    push_tag_prefix(48);
    push_header("1", 8'h20);
    push_rand(1);
    // payload that carries the tag must not restart the hunt
    push_header("60", 8'h0D);
    push_tag_prefix(TAG_LEN);
    push_text("4\r\n\r");
    // disconnects within the tag, the length and the separator
    push_tag_prefix(30);
    push_byte(1'b1, 8'h00);
    push_tag_prefix(TAG_LEN);
    push_text("5");
    push_byte(1'b1, 8'h5A);
    push_tag_prefix(TAG_LEN);
    push_text("4\r\n");
    push_byte(1'b1, 8'h00);
    push_header("2", 8'h20);
    push_rand(2);
    push_drain();

    // Random: mostly well-formed frames, some broken headers and noise
    rand_start = n_items;
    next_drain = n_items + 100;
    while (n_items - rand_start < 300) begin
      if (n_items >= next_drain) begin
        push_drain();
        next_drain += 100;
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        push_rand($urandom_range(0, 3));
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
        ds = $sformatf("%0d", len);
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(1, 3);
          repeat (k) ds = {"0", ds};
        end
        push_header(ds, WS_SET[$urandom_range(0, 5)]);
        if (len > 0 && $urandom_range(0, 11) == 0) begin
          push_rand($urandom_range(0, len - 1));
          push_byte(1'b1, 8'($urandom_range(0, 255)));
        end else begin
          push_rand(len);
        end
      end else if (sel < 70) begin
        push_tag_prefix(TAG_LEN);
        case ($urandom_range(0, 3))
          0: push_byte(1'b0, stray_char());
          1: push_byte(1'b0, WS_SET[$urandom_range(0, 5)]);
          2: begin
            push_text($sformatf("%0d", $urandom_range(0, 999)));
            push_byte(1'b0, stray_char());
          end
          default: push_text($sformatf("%0d", $urandom_range(16777216, 999999999)));
        endcase
      end else if (sel < 80) begin
        push_tag_prefix($urandom_range(1, TAG_LEN - 1));
        push_rand($urandom_range(1, 4));
      end else if (sel < 90) begin
        push_tag_prefix($urandom_range(1, TAG_LEN));
        if ($urandom_range(0, 1) == 0) push_text($sformatf("%0d", $urandom_range(0, 99)));
        push_byte(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 10))
          push_byte(($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    started = 1'b1;

    // Let the last beat be offered and accepted before checking for drain
    wait (stream_q.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (frame_out_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("mjpeg_multipart_deframer regression: pass");
    end else begin
      $display("mjpeg_multipart_deframer regression: fail");
    end
    $finish;
  end

endmodule
